[rtl/gbn_sw_pkg.sv]
// ----------------------------------------------------------------------------
// Go-Back-N send window package
// Field widths, operation and status codes, register indexes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gbn_sw_pkg;

  localparam int OP_W       = 2;
  localparam int SEQ_W      = 32;
  localparam int TIMER_W    = 24;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 5;
  localparam int CNT_OUT_W  = 5;
  localparam int WIN_CFG_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - (SLOT_OUT_W + SEQ_W + CNT_OUT_W + 1 + TIMER_W);

  localparam logic [TIMER_W-1:0] TIMEOUT_RST = 24'd500000;

  localparam logic [OP_W-1:0] OP_SEND   = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK    = 2'd1;
  localparam logic [OP_W-1:0] OP_AGE    = 2'd2;
  localparam logic [OP_W-1:0] OP_RESEND = 2'd3;

  localparam logic [STATUS_W-1:0] ST_SENT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_AGED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESEND  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOTHING = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ = 2'd2;

  typedef struct packed {
    logic                cfg_write;
    logic                in_latch;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                send_do;
    logic                ack_do;
    logic                walk_init;
    logic                age_step;
    logic                reload_step;
    logic                mod_step;
    logic                cap_oldest;
    logic                emit;
    logic                emit_walk;
  } gbn_sw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            ack_ok;
    logic            walk_done;
    logic            age_done;
    logic            entry_last;
    logic            mod_needed;
    logic            mod_last;
    logic            out_free;
  } gbn_sw_sts_t;

endpackage

[rtl/gbn_sw_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_sw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/gbn_sw_ctrl.sv]
// ----------------------------------------------------------------------------
// Go-Back-N send window controller
// Sequences configuration, the per-operation steps, the timer walks and the
// delivery of result items.
// ----------------------------------------------------------------------------
module gbn_sw_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_valid_i,
  output logic                     s_ready_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  gbn_sw_pkg::gbn_sw_sts_t  sts_i,
  output gbn_sw_pkg::gbn_sw_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MOD      = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_AGE      = 3'd3;
  localparam logic [2:0] S_RELOAD   = 3'd4;
  localparam logic [2:0] S_RD       = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       resend_walk;

  assign resend_walk = (sts_i.op == gbn_sw_pkg::OP_RESEND) && !sts_i.empty;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cfg_ready_o = 1'b1;
        s_ready_o   = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_write = 1'b1;
          if (sts_i.mod_needed) begin
            state_d = S_MOD;
          end
        end else if (s_valid_i) begin
          cmd_o.in_latch = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_IDLE;
        end
      end
      S_DISPATCH: begin
        cmd_o.res_load = 1'b1;
        state_d        = S_RD;
        case (sts_i.op)
          gbn_sw_pkg::OP_SEND: begin
            if (sts_i.full) begin
              cmd_o.res_status = gbn_sw_pkg::ST_FULL;
            end else begin
              cmd_o.res_status = gbn_sw_pkg::ST_SENT;
              cmd_o.send_do    = 1'b1;
            end
          end
          gbn_sw_pkg::OP_ACK: begin
            if (sts_i.empty) begin
              cmd_o.res_status = gbn_sw_pkg::ST_NOTHING;
            end else if (sts_i.ack_ok) begin
              cmd_o.res_status = gbn_sw_pkg::ST_MOVED;
              cmd_o.ack_do     = 1'b1;
            end else begin
              cmd_o.res_status = gbn_sw_pkg::ST_IGNORED;
            end
          end
          gbn_sw_pkg::OP_AGE: begin
            if (sts_i.empty) begin
              cmd_o.res_status = gbn_sw_pkg::ST_NOTHING;
            end else begin
              cmd_o.res_status = gbn_sw_pkg::ST_AGED;
              cmd_o.walk_init  = 1'b1;
              state_d          = S_AGE;
            end
          end
          gbn_sw_pkg::OP_RESEND: begin
            if (sts_i.empty) begin
              cmd_o.res_status = gbn_sw_pkg::ST_NOTHING;
            end else begin
              cmd_o.res_status = gbn_sw_pkg::ST_RESEND;
              cmd_o.walk_init  = 1'b1;
              state_d          = S_RELOAD;
            end
          end
          default: begin
            cmd_o.res_status = gbn_sw_pkg::ST_NOTHING;
          end
        endcase
      end
      S_AGE: begin
        cmd_o.age_step = 1'b1;
        if (sts_i.age_done) begin
          state_d = S_RD;
        end
      end
      S_RELOAD: begin
        cmd_o.reload_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.walk_init = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        cmd_o.cap_oldest = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_walk = resend_walk;
          if (!resend_walk || sts_i.entry_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/gbn_sw_dpath.sv]
// ----------------------------------------------------------------------------
// Go-Back-N send window datapath
// Window registers, ring distance and ack range logic, the slot timer RAM
// with its walk pointer, the serial remainder unit and the result register.
// ----------------------------------------------------------------------------
module gbn_sw_dpath #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gbn_sw_pkg::gbn_sw_cmd_t                cmd_i,
  output gbn_sw_pkg::gbn_sw_sts_t                sts_o,
  input  logic [gbn_sw_pkg::IN_DATA_W-1:0]       s_tdata_i,
  input  logic [gbn_sw_pkg::OP_W-1:0]            s_tuser_i,
  input  logic [gbn_sw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gbn_sw_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                   m_ready_i,
  output logic                                   m_valid_o,
  output logic [gbn_sw_pkg::OUT_DATA_W-1:0]      m_tdata_o,
  output logic [gbn_sw_pkg::STATUS_W-1:0]        m_tuser_o,
  output logic                                   m_tlast_o
);

  localparam int RING_MAX = 2 * WINDOW_MAX;
  localparam int SLOT_W   = $clog2(RING_MAX);
  localparam int RW       = SLOT_W + 1;
  localparam int WIN_W    = $clog2(WINDOW_MAX + 1);
  localparam int WIN_RST  = (WINDOW_MAX < 4) ? WINDOW_MAX : 4;
  localparam int SQW      = gbn_sw_pkg::SEQ_W;
  localparam int TW       = gbn_sw_pkg::TIMER_W;
  localparam int BIT_W    = $clog2(SQW);
  localparam int CW       = gbn_sw_pkg::WIN_CFG_W + 1;
  localparam int SOW      = gbn_sw_pkg::SLOT_OUT_W;
  localparam int NOW      = gbn_sw_pkg::CNT_OUT_W;
  localparam int PADW     = gbn_sw_pkg::OUT_PAD_W;

  logic [WIN_W-1:0]               window_q;
  logic [TW-1:0]                  timeout_q;
  logic [SLOT_W-1:0]              base_slot_q, next_slot_q;
  logic [SQW-1:0]                 base_seq_q;
  logic [gbn_sw_pkg::OP_W-1:0]    op_q;
  logic [SQW-1:0]                 ack_q;
  logic [TW-1:0]                  el_q;
  logic [SLOT_W-1:0]              k_q, ws_q, pend_addr_q;
  logic                           pend_q;
  logic [SLOT_W-1:0]              rem_q;
  logic [BIT_W-1:0]               bit_q;
  logic [gbn_sw_pkg::STATUS_W-1:0] res_status_q;
  logic [SLOT_W-1:0]              res_slot_q;
  logic [SQW-1:0]                 res_seq_q;
  logic [TW-1:0]                  oldest_q;
  logic                           m_valid_q;
  logic [gbn_sw_pkg::OUT_DATA_W-1:0] m_data_q;
  logic [gbn_sw_pkg::STATUS_W-1:0] m_status_q;
  logic                           m_last_q;

  logic [RW-1:0]     ring, ring_dist, ack_sum, ack_base, rem_sh, rem_nx;
  logic [SLOT_W-1:0] n;
  logic              empty, walk_done, entry_last, walk_adv;
  logic [SQW-1:0]    ack_diff;
  logic              ack_ok;
  logic [CW-1:0]     win_clamp;
  logic [TW-1:0]     ram_rdata, ram_wdata, age_val;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] e_slot;
  logic [SQW-1:0]    e_seq;
  logic [TW-1:0]     e_old;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [RW-1:0] r);
    logic [RW-1:0] s1;
    s1 = RW'(s) + RW'(1);
    return (s1 == r) ? '0 : s1[SLOT_W-1:0];
  endfunction

  assign ring = RW'({window_q, 1'b0});

  always_comb begin
    if (next_slot_q >= base_slot_q) begin
      ring_dist = RW'(next_slot_q) - RW'(base_slot_q);
    end else begin
      ring_dist = RW'(next_slot_q) + ring - RW'(base_slot_q);
    end
  end

  assign n          = ring_dist[SLOT_W-1:0];
  assign empty      = (n == '0);
  assign walk_done  = (k_q == n);
  assign entry_last = ((RW'(k_q) + RW'(1)) == RW'(n));

  assign ack_diff = ack_q - base_seq_q;
  assign ack_ok   = (ack_diff != '0) && (ack_diff <= SQW'(n));
  assign ack_sum  = RW'(base_slot_q) + RW'(ack_diff[SLOT_W-1:0]);
  assign ack_base = (ack_sum >= ring) ? (ack_sum - ring) : ack_sum;

  assign rem_sh = {rem_q, base_seq_q[bit_q]};
  assign rem_nx = (rem_sh >= ring) ? (rem_sh - ring) : rem_sh;

  always_comb begin
    win_clamp = {1'b0, cfg_data_i[gbn_sw_pkg::WIN_CFG_W-1:0]};
    if (win_clamp == '0) begin
      win_clamp = CW'(1);
    end else if (win_clamp > CW'(WINDOW_MAX)) begin
      win_clamp = CW'(WINDOW_MAX);
    end
  end

  assign age_val   = (ram_rdata > el_q) ? (ram_rdata - el_q) : '0;
  assign ram_we    = cmd_i.send_do || (cmd_i.reload_step && !walk_done) || pend_q;
  assign ram_waddr = pend_q ? pend_addr_q : (cmd_i.send_do ? next_slot_q : ws_q);
  assign ram_wdata = pend_q ? age_val : timeout_q;
  assign ram_raddr = cmd_i.age_step ? ws_q : base_slot_q;

  gbn_sw_ram #(
    .WIDTH(TW),
    .DEPTH(RING_MAX)
  ) u_timer_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign walk_adv = ((cmd_i.age_step || cmd_i.reload_step) && !walk_done) || cmd_i.emit_walk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WIN_W'(WIN_RST);
      timeout_q   <= gbn_sw_pkg::TIMEOUT_RST;
      base_slot_q <= '0;
      next_slot_q <= '0;
      base_seq_q  <= '0;
      k_q         <= '0;
      ws_q        <= '0;
      pend_q      <= 1'b0;
      rem_q       <= '0;
      bit_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.cfg_write) begin
        case (cfg_index_i)
          gbn_sw_pkg::CFG_WINDOW: begin
            if (empty) begin
              window_q <= WIN_W'(win_clamp);
            end
          end
          gbn_sw_pkg::CFG_TIMEOUT: begin
            timeout_q <= cfg_data_i[TW-1:0];
          end
          gbn_sw_pkg::CFG_INIT_SEQ: begin
            if (empty) begin
              base_seq_q <= cfg_data_i[SQW-1:0];
            end
          end
          default: begin
          end
        endcase
        rem_q <= '0;
        bit_q <= BIT_W'(SQW - 1);
      end
      if (cmd_i.mod_step) begin
        rem_q <= rem_nx[SLOT_W-1:0];
        bit_q <= bit_q - BIT_W'(1);
        if (bit_q == '0) begin
          base_slot_q <= rem_nx[SLOT_W-1:0];
          next_slot_q <= rem_nx[SLOT_W-1:0];
        end
      end
      if (cmd_i.send_do) begin
        next_slot_q <= slot_inc(next_slot_q, ring);
      end
      if (cmd_i.ack_do) begin
        base_seq_q  <= ack_q;
        base_slot_q <= ack_base[SLOT_W-1:0];
      end
      if (cmd_i.walk_init) begin
        k_q  <= '0;
        ws_q <= base_slot_q;
      end else if (walk_adv) begin
        k_q  <= k_q + SLOT_W'(1);
        ws_q <= slot_inc(ws_q, ring);
      end
      pend_q <= cmd_i.age_step && !walk_done;
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign e_slot = cmd_i.emit_walk ? ws_q : res_slot_q;
  assign e_seq  = cmd_i.emit_walk ? (base_seq_q + SQW'(k_q)) : res_seq_q;
  assign e_old  = empty ? '0 : oldest_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_latch) begin
      op_q  <= s_tuser_i;
      ack_q <= s_tdata_i[SQW-1:0];
      el_q  <= s_tdata_i[SQW+TW-1:SQW];
    end
    pend_addr_q <= ws_q;
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      if (cmd_i.res_status == gbn_sw_pkg::ST_SENT) begin
        res_slot_q <= next_slot_q;
        res_seq_q  <= base_seq_q + SQW'(n);
      end else begin
        res_slot_q <= '0;
        res_seq_q  <= '0;
      end
    end
    if (cmd_i.cap_oldest) begin
      oldest_q <= ram_rdata;
    end
    if (cmd_i.emit) begin
      m_status_q <= res_status_q;
      m_last_q   <= cmd_i.emit_walk ? entry_last : 1'b1;
      m_data_q   <= {{PADW{1'b0}}, e_old, (e_old == '0), NOW'(n), e_seq, SOW'(e_slot)};
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.empty      = empty;
  assign sts_o.full       = (RW'(n) >= RW'(window_q));
  assign sts_o.ack_ok     = ack_ok;
  assign sts_o.walk_done  = walk_done;
  assign sts_o.age_done   = walk_done && !pend_q;
  assign sts_o.entry_last = entry_last;
  assign sts_o.mod_needed = empty && ((cfg_index_i == gbn_sw_pkg::CFG_WINDOW) ||
                                      (cfg_index_i == gbn_sw_pkg::CFG_INIT_SEQ));
  assign sts_o.mod_last   = (bit_q == '0);
  assign sts_o.out_free   = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign m_tdata_o = m_data_q;
  assign m_tuser_o = m_status_q;
  assign m_tlast_o = m_last_q;

endmodule

[rtl/go_back_n_send_window_unit.sv]
// ----------------------------------------------------------------------------
// Go-Back-N send window unit
// Keeps the sender window of a Go-Back-N link over a ring of twice the window
// size: send requests claim a slot and a sequence number, acknowledgements
// inside the outstanding range slide the base, time updates age the slot
// timers with saturation at zero, and a resend-all reloads the timers and
// lists every outstanding packet, one result item per packet with tlast on
// the final one. Items are handled one at a time. The aging and resend
// passes walk the timer RAM one slot per cycle over the packets in flight.
// A write of the window size or of the initial sequence number while the
// window is empty runs a bit-serial remainder to place the base slot,
// during which neither the input nor the configuration port is ready.
// ----------------------------------------------------------------------------
module go_back_n_send_window_unit #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: ack_number[31:0], elapsed[55:32].
  input  logic [gbn_sw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: op[1:0].
  input  logic [gbn_sw_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: slot[4:0], seq_number[36:5], outstanding[41:37],
  // window_idle[42], oldest_timer[66:43], zero fill[71:67].
  output logic [gbn_sw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0: status[2:0].
  output logic [gbn_sw_pkg::STATUS_W-1:0]      m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gbn_sw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gbn_sw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  gbn_sw_pkg::gbn_sw_cmd_t cmd;
  gbn_sw_pkg::gbn_sw_sts_t sts;

  gbn_sw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbn_sw_dpath #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

[rtl/gbn_sw_checker.sv]
// ----------------------------------------------------------------------------
// Go-Back-N send window checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module gbn_sw_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [gbn_sw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [gbn_sw_pkg::STATUS_W-1:0]   m_axis_tuser,
  input logic                              m_axis_tlast
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("Result item valid during reset.");

  a_idle_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[42] == (m_axis_tdata[66:43] == 24'd0)))
    else $error("Window idle flag disagrees with the oldest timer.");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == gbn_sw_pkg::ST_NOTHING)) |->
      ((m_axis_tdata[41:37] == 5'd0) && (m_axis_tdata[36:0] == 37'd0)))
    else $error("Empty-window result carries a slot, sequence or count.");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != gbn_sw_pkg::ST_RESEND)) |-> m_axis_tlast)
    else $error("Single result item without tlast.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("Stalled result item changed.");

endmodule

bind go_back_n_send_window_unit gbn_sw_checker u_gbn_sw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Go-Back-N send window unit testbench
// Drives send, ack, aging and resend-all items into the stream input with
// random gaps. It changes the window size, the timeout and the initial
// sequence number between phases. Each result item is compared field by
// field with a prediction kept from the accepted items and register writes.
// ----------------------------------------------------------------------------

import gbn_sw_pkg::*;

typedef struct packed {
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [SEQ_W-1:0]      seq_number;
  logic                  last;
  logic [CNT_OUT_W-1:0]  outstanding;
  logic                  window_idle;
  logic [TIMER_W-1:0]    oldest_timer;
} window_result_t;

class send_window_model #(int WMAX = 16);
  int unsigned win_size;
  int unsigned timeout;
  int unsigned init_seq;
  int unsigned base_slot;
  int unsigned next_slot;
  int unsigned base_seq;
  int unsigned timers[2*WMAX];
  window_result_t pending_results[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned status_seen[8];

  function new();
    win_size  = 4;
    timeout   = TIMEOUT_RST;
    init_seq  = 0;
    base_seq  = 0;
    base_slot = 0;
    next_slot = 0;
    foreach (timers[i]) timers[i] = 0;
    errors  = 0;
    checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function int unsigned ring_len();
    return 2 * win_size;
  endfunction

  function int unsigned in_flight();
    return (next_slot + ring_len() - base_slot) % ring_len();
  endfunction

  function void emit(logic [STATUS_W-1:0] status, int unsigned slot, int unsigned seq,
                     bit last);
    window_result_t r;
    int unsigned n;
    n = in_flight();
    r.status       = status;
    r.slot         = slot[SLOT_OUT_W-1:0];
    r.seq_number   = seq;
    r.last         = last;
    r.outstanding  = n[CNT_OUT_W-1:0];
    r.oldest_timer = (n != 0) ? timers[base_slot] : 0;
    r.window_idle  = (n == 0) || (r.oldest_timer == 0);
    pending_results.push_back(r);
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int unsigned w;
    w = data[WIN_CFG_W-1:0];
    if (idx == CFG_WINDOW) begin
      // The ring is only rebuilt while nothing is in flight.
      if (in_flight() == 0) begin
        win_size  = (w < 1) ? 1 : (w > WMAX) ? WMAX : w;
        base_slot = base_seq % ring_len();
        next_slot = base_slot;
      end
    end else if (idx == CFG_TIMEOUT) begin
      timeout = data[TIMER_W-1:0];
    end else if (idx == CFG_INIT_SEQ) begin
      init_seq = data;
      if (in_flight() == 0) begin
        base_seq  = data;
        base_slot = base_seq % ring_len();
        next_slot = base_slot;
      end
    end
  endfunction

  function void note_request(logic [OP_W-1:0] op, logic [SEQ_W-1:0] ack,
                             logic [TIMER_W-1:0] elapsed);
    int unsigned n;
    int unsigned d;
    int unsigned s;
    int unsigned k;
    n = in_flight();
    if (op == OP_SEND) begin
      if (n >= win_size) begin
        emit(ST_FULL, 0, 0, 1'b1);
      end else begin
        s = next_slot;
        timers[s] = timeout;
        next_slot = (s + 1) % ring_len();
        emit(ST_SENT, s, base_seq + n, 1'b1);
      end
    end else if (n == 0) begin
      emit(ST_NOTHING, 0, 0, 1'b1);
    end else if (op == OP_ACK) begin
      d = ack - base_seq;
      if (d >= 1 && d <= n) begin
        base_seq  = ack;
        base_slot = (base_slot + d) % ring_len();
        emit(ST_MOVED, 0, 0, 1'b1);
      end else begin
        emit(ST_IGNORED, 0, 0, 1'b1);
      end
    end else if (op == OP_AGE) begin
      for (k = 0; k < n; k++) begin
        s = (base_slot + k) % ring_len();
        timers[s] = (timers[s] > elapsed) ? timers[s] - elapsed : 0;
      end
      emit(ST_AGED, 0, 0, 1'b1);
    end else begin
      for (k = 0; k < n; k++) timers[(base_slot + k) % ring_len()] = timeout;
      for (k = 0; k < n; k++)
        emit(ST_RESEND, (base_slot + k) % ring_len(), base_seq + k, k + 1 == n);
    end
  endfunction

  function void compare(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(window_result_t got);
    window_result_t want;
    if (pending_results.size() == 0) begin
      $error("result item with no prediction: status %0d seq 0x%0h",
             got.status, got.seq_number);
      errors++;
    end else begin
      want = pending_results.pop_front();
      compare("status", want.status, got.status);
      compare("slot", want.slot, got.slot);
      compare("seq_number", want.seq_number, got.seq_number);
      compare("last", want.last, got.last);
      compare("outstanding", want.outstanding, got.outstanding);
      compare("window_idle", want.window_idle, got.window_idle);
      compare("oldest_timer", want.oldest_timer, got.oldest_timer);
      checked++;
      status_seen[want.status]++;
    end
  endfunction
endclass

module tb;

  localparam int WIN_LIMIT     = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 35;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  send_window_model #(WIN_LIMIT) model;

  bit          no_gaps    = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycles     = 0;

  go_back_n_send_window_unit #(
    .WINDOW_MAX(WIN_LIMIT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("go_back_n_send_window_unit regression: fail");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned stall;
    window_result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
      got.status       = m_axis_tuser;
      got.slot         = m_axis_tdata[4:0];
      got.seq_number   = m_axis_tdata[36:5];
      got.outstanding  = m_axis_tdata[41:37];
      got.window_idle  = m_axis_tdata[42];
      got.oldest_timer = m_axis_tdata[66:43];
      got.last         = m_axis_tlast;
      model.check_result(got);
    end
  end

  task automatic push_item(logic [OP_W-1:0] op, logic [SEQ_W-1:0] ack,
                           logic [TIMER_W-1:0] elapsed);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {elapsed, ack};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    model.note_request(op, ack, elapsed);
    items_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (model.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    model.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  // Mostly sends and in-range acks with aging in between, so the window
  // fills, slides and wraps; the rest are stray acks and resends.
  task automatic random_item();
    logic [OP_W-1:0]    op;
    logic [SEQ_W-1:0]   ack;
    logic [TIMER_W-1:0] elapsed;
    int unsigned n;
    int unsigned pick;
    n       = model.in_flight();
    pick    = $urandom_range(0, 99);
    ack     = $urandom();
    elapsed = $urandom();
    if (pick < 45) begin
      op = OP_SEND;
    end else if (pick < 76) begin
      op = OP_ACK;
      if (pick < 68 && n != 0) begin
        ack = model.base_seq + $urandom_range(1, n);
      end else begin
        case ($urandom_range(0, 3))
          0: ack = model.base_seq;
          1: ack = model.base_seq + n + $urandom_range(1, 40);
          2: ack = model.base_seq - $urandom_range(1, 8);
          default: ;
        endcase
      end
    end else if (pick < 91) begin
      op = OP_AGE;
      case ($urandom_range(0, 3))
        0: elapsed = $urandom_range(0, model.timeout);
        1: elapsed = $urandom_range(0, model.timeout / 8);
        2: elapsed = pick[0] ? '0 : '1;
        default: ;
      endcase
    end else begin
      op = OP_RESEND;
    end
    push_item(op, ack, elapsed);
  endtask

  task automatic random_settings();
    case ($urandom_range(0, 3))
      0: write_register(CFG_WINDOW, 32'd1);
      1: write_register(CFG_WINDOW, WIN_LIMIT);
      default: write_register(CFG_WINDOW, $urandom());
    endcase
    case ($urandom_range(0, 4))
      0: write_register(CFG_TIMEOUT, 32'd0);
      1: write_register(CFG_TIMEOUT, 32'h00FF_FFFF);
      2: write_register(CFG_TIMEOUT, $urandom_range(1, 200));
      default: write_register(CFG_TIMEOUT, $urandom());
    endcase
    case ($urandom_range(0, 2))
      0: write_register(CFG_INIT_SEQ, 32'hFFFF_FFFF - $urandom_range(0, 40));
      1: write_register(CFG_INIT_SEQ, $urandom_range(0, 40));
      default: write_register(CFG_INIT_SEQ, $urandom());
    endcase
    if ($urandom_range(0, 3) == 0) write_register(CFG_UNUSED, $urandom());
  endtask

  initial begin : stimulus
    int unsigned n;
    int p;
    model = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty window, fill to full, aging extremes, stray acks and a resend.
    push_item(OP_ACK, $urandom(), $urandom());
    push_item(OP_AGE, $urandom(), '1);
    push_item(OP_RESEND, $urandom(), $urandom());
    repeat (5) push_item(OP_SEND, $urandom(), $urandom());
    push_item(OP_AGE, $urandom(), '0);
    push_item(OP_ACK, model.base_seq, $urandom());
    push_item(OP_ACK, model.base_seq + 5, $urandom());
    push_item(OP_RESEND, $urandom(), $urandom());
    push_item(OP_AGE, $urandom(), '1);
    push_item(OP_ACK, model.base_seq + 1, $urandom());
    push_item(OP_SEND, $urandom(), $urandom());
    wait_for_results();

    // Writes while packets are in flight.
    write_register(CFG_WINDOW, 32'd16);
    write_register(CFG_INIT_SEQ, 32'h8000_0000);
    push_item(OP_ACK, model.base_seq + 4, $urandom());
    wait_for_results();

    // Window of one, zero timeout, sequence wrap.
    write_register(CFG_WINDOW, 32'hFFFF_FFE0);
    write_register(CFG_INIT_SEQ, 32'hFFFF_FFFF);
    write_register(CFG_TIMEOUT, 32'hFF00_0000);
    push_item(OP_SEND, $urandom(), $urandom());
    push_item(OP_SEND, $urandom(), $urandom());
    push_item(OP_AGE, $urandom(), 24'd1);
    push_item(OP_RESEND, $urandom(), $urandom());
    push_item(OP_ACK, 32'd0, $urandom());
    wait_for_results();

    // Oversized window clamps to the maximum.
    write_register(CFG_WINDOW, 32'h0000_001F);
    write_register(CFG_TIMEOUT, 32'h00FF_FFFF);
    write_register(CFG_INIT_SEQ, 32'hFFFF_FFF8);
    write_register(CFG_UNUSED, $urandom());
    repeat (3) push_item(OP_SEND, $urandom(), $urandom());
    push_item(OP_RESEND, $urandom(), $urandom());
    wait_for_results();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      no_gaps = (p % 4 == 3);
      repeat (PHASE_ITEMS) begin
        random_item();
        if ($urandom_range(0, 29) == 0) wait_for_results();
      end
      n = model.in_flight();
      if (n != 0 && $urandom_range(0, 2) != 0)
        push_item(OP_ACK, model.base_seq + n, $urandom());
      wait_for_results();
      random_settings();
    end
    no_gaps = 1'b0;

    wait_for_results();
    repeat (16) @(posedge clk_i);
    $display("Covered %0d input items over %0d register writes, %0d result items checked.",
             items_sent, cfg_writes, model.checked);
    $display("Results: sent %0d, full %0d, moved %0d, ignored %0d, aged %0d, resend %0d, empty %0d.",
             model.status_seen[ST_SENT], model.status_seen[ST_FULL],
             model.status_seen[ST_MOVED], model.status_seen[ST_IGNORED],
             model.status_seen[ST_AGED], model.status_seen[ST_RESEND],
             model.status_seen[ST_NOTHING]);
    if (model.errors == 0 && model.pending_results.size() == 0) begin
      $display("go_back_n_send_window_unit regression: pass");
    end else begin
      $display("go_back_n_send_window_unit regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gbn_sw_pkg.sv
rtl/gbn_sw_ram.sv
rtl/gbn_sw_ctrl.sv
rtl/gbn_sw_dpath.sv
rtl/go_back_n_send_window_unit.sv
rtl/gbn_sw_checker.sv
tb/tb.sv
